// File: rtl/srm_pkg.sv
// Shared types and constants of the subset rule matcher.
package srm_pkg;

  localparam int VECTOR_BITS = 64;
  localparam int MAX_RULES   = 256;
  localparam int FIELD_BITS  = 64;
  localparam int TGT_BITS    = 6;
  localparam int CNT_W       = $clog2(MAX_RULES + 1);
  localparam int STEP_W      = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

  typedef enum logic [1:0] {
    OP_CLEAR = 2'd0,
    OP_LOAD  = 2'd1,
    OP_CHECK = 2'd2
  } op_t;

  typedef struct packed {
    logic [VECTOR_BITS-1:0] mask;
    logic [TGT_BITS-1:0]    target;
  } rule_t;

  typedef struct packed {
    logic load;
    logic rotate;
  } cell_ctl_t;

endpackage

// File: rtl/srm_in_if.sv
// Input word channel of the subset rule matcher.
interface srm_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          op;
  logic [srm_pkg::FIELD_BITS-1:0]      rule_mask;
  logic [srm_pkg::TGT_BITS-1:0]        rule_target;
  logic [srm_pkg::FIELD_BITS-1:0]      pile_bits;

  modport source (output valid, op, rule_mask, rule_target, pile_bits, input ready);
  modport sink   (input valid, op, rule_mask, rule_target, pile_bits, output ready);
endinterface

// File: rtl/srm_out_if.sv
// Result word channel of the subset rule matcher.
interface srm_out_if;
  logic valid;
  logic ready;
  logic matched;
  logic status;

  modport source (output valid, matched, status, input ready);
  modport sink   (input valid, matched, status, output ready);
endinterface

// File: rtl/srm_cell.sv
// One rule cell of the storage chain: hold, shift in from the previous cell, or rotate.
module srm_cell (
  input  logic               clk,
  input  srm_pkg::cell_ctl_t ctl,
  input  srm_pkg::rule_t     from_prev,
  input  srm_pkg::rule_t     from_next,
  output srm_pkg::rule_t     rule
);

  srm_pkg::rule_t rule_r;

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      rule_r <= from_prev;
    end else if (ctl.rotate) begin
      rule_r <= from_next;
    end
  end

  assign rule = rule_r;

endmodule

// File: rtl/subset_rule_matcher_core.sv
// Top level of the subset rule matcher: control, head comparator and rule cell chain.
//
//  channel | dir | handshake     | payload
//  in_if   | in  | valid / ready | op, rule_mask, rule_target, pile_bits
//  out_if  | out | valid / ready | matched, status
//
// Clear, load and unused op words give their result one cycle after acceptance.
// A check takes MAX_RULES + 1 cycles: the rule ring rotates once fully past the
// comparator at cell 0, one rule per cycle, and returns to its original order.
// Reset empties the table; rule cells hold no reset value.
// A new word is taken only when the controller is idle and the result register is
// free or being emptied; out_if stalls hold the result register.
module subset_rule_matcher_core (
  input logic       clk,
  input logic       rst_n,
  srm_in_if.sink    in_if,
  srm_out_if.source out_if
);

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_SCAN
  } state_t;

  localparam int N = srm_pkg::MAX_RULES;

  state_t                          state_r;
  logic [srm_pkg::CNT_W-1:0]       cnt_r;
  logic [srm_pkg::STEP_W-1:0]      step_r;
  logic [srm_pkg::VECTOR_BITS-1:0] pile_r;
  logic                            match_r;
  logic                            out_valid_r;
  logic                            out_valid_nxt;
  logic                            out_matched_r;
  logic                            out_status_r;

  logic                            in_ready;
  logic                            accept;
  logic                            table_full;
  logic                            last_step;
  logic                            hit;
  logic [srm_pkg::FIELD_BITS-1:0]  pile_w;
  srm_pkg::op_t                    op;
  srm_pkg::cell_ctl_t              ctl;
  srm_pkg::rule_t                  new_rule;
  srm_pkg::rule_t                  chain [N];

  assign op         = srm_pkg::op_t'(in_if.op);
  assign in_ready   = (state_r == ST_IDLE) && (!out_valid_r || out_if.ready);
  assign accept     = in_if.valid && in_ready;
  assign table_full = (cnt_r == srm_pkg::CNT_W'(N));
  assign last_step  = (step_r == srm_pkg::STEP_W'(N - 1));

  assign out_valid_nxt = (out_valid_r && !out_if.ready)
                      || (accept && (op != srm_pkg::OP_CHECK))
                      || ((state_r == ST_SCAN) && last_step);

  assign new_rule.mask   = in_if.rule_mask[srm_pkg::VECTOR_BITS-1:0];
  assign new_rule.target = in_if.rule_target;

  assign ctl.load   = accept && (op == srm_pkg::OP_LOAD) && !table_full;
  assign ctl.rotate = (state_r == ST_SCAN);

  for (genvar i = 0; i < N; i++) begin : g_cell
    srm_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .from_prev ((i == 0) ? new_rule : chain[(i + N - 1) % N]),
      .from_next (chain[(i + 1) % N]),
      .rule      (chain[i])
    );
  end

  assign pile_w = srm_pkg::FIELD_BITS'(pile_r);
  assign hit = (srm_pkg::CNT_W'(step_r) < cnt_r)
            && ({1'b0, chain[0].target} < (srm_pkg::TGT_BITS + 1)'(srm_pkg::VECTOR_BITS))
            && !pile_w[chain[0].target]
            && ((chain[0].mask & pile_r) == chain[0].mask);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            case (op)
              srm_pkg::OP_CLEAR: begin
                cnt_r         <= '0;
                out_matched_r <= 1'b0;
                out_status_r  <= 1'b0;
              end
              srm_pkg::OP_LOAD: begin
                if (!table_full) begin
                  cnt_r <= cnt_r + srm_pkg::CNT_W'(1);
                end
                out_matched_r <= 1'b0;
                out_status_r  <= table_full;
              end
              srm_pkg::OP_CHECK: begin
                state_r <= ST_SCAN;
                step_r  <= '0;
                match_r <= 1'b0;
                pile_r  <= in_if.pile_bits[srm_pkg::VECTOR_BITS-1:0];
              end
              default: begin
                out_matched_r <= 1'b0;
                out_status_r  <= 1'b0;
              end
            endcase
          end
        end
        ST_SCAN: begin
          match_r <= match_r || hit;
          step_r  <= step_r + srm_pkg::STEP_W'(1);
          if (last_step) begin
            state_r       <= ST_IDLE;
            out_matched_r <= match_r || hit;
            out_status_r  <= 1'b0;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_if.ready    = in_ready;
  assign out_if.valid   = out_valid_r;
  assign out_if.matched = out_matched_r;
  assign out_if.status  = out_status_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= srm_pkg::CNT_W'(N))
    else $error("rule count beyond table depth");

  a_check_latency: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == srm_pkg::OP_CHECK) |-> ##N (last_step && state_r == ST_SCAN))
    else $error("check scan length wrong");

  a_full_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == srm_pkg::OP_LOAD && table_full)
      |=> (out_valid_r && out_status_r && $stable(cnt_r)))
    else $error("full table load not flagged");

  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && op == srm_pkg::OP_LOAD && !table_full)
      |=> (cnt_r == $past(cnt_r) + srm_pkg::CNT_W'(1)))
    else $error("load did not append rule");

endmodule
